// File: src/mfbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbi_pkg
// Types, constants and the control program of the motor force boost integrator.
// ----------------------------------------------------------------------------
package mfbi_pkg;

  localparam int PC_W        = 3;
  localparam int FRAC        = 12;
  localparam int DECAY_SHIFT = 10;
  localparam int QONE        = 4096;
  localparam int CUBIC_GAIN  = 410;
  localparam int ERR_W       = 14;
  localparam int ACC_W       = 20;
  localparam int MUL_W       = 18;

  localparam logic CFG_BOOST_RATE     = 1'b0;
  localparam logic CFG_MOTOR_CHANNELS = 1'b1;

  localparam logic ACT_SENSOR = 1'b0;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {OPA_DIFF, OPA_ERR, OPA_PROD} opa_t;
  typedef enum logic [1:0] {OPB_BOOST, OPB_ERR, OPB_CUBIC} opb_t;
  typedef enum logic [1:0] {ACC_NOP, ACC_INIT, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_MOTOR, EMIT_PASS} emit_t;

  typedef struct packed {
    opa_t    opa;
    opb_t    opb;
    logic    mul_en;
    acc_op_t acc_op;
    logic    jmp_pass;
    pc_t     target;
    emit_t   emit;
    logic    last;
  } ucode_t;

  typedef struct packed {
    logic   busy;
    ucode_t word;
  } seq_ctrl_t;

  localparam pc_t STEP_PASS = 3'd6;

  localparam ucode_t UC_NOP = '{opa: OPA_DIFF, opb: OPB_BOOST, mul_en: 1'b0,
                                acc_op: ACC_NOP, jmp_pass: 1'b0, target: '0,
                                emit: EMIT_NONE, last: 1'b0};

  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    w = UC_NOP;
    unique case (pc)
      3'd0: begin
        w.opa      = OPA_DIFF;
        w.opb      = OPB_BOOST;
        w.mul_en   = 1'b1;
        w.acc_op   = ACC_INIT;
        w.jmp_pass = 1'b1;
        w.target   = STEP_PASS;
      end
      3'd1: begin
        w.opa    = OPA_ERR;
        w.opb    = OPB_ERR;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ADD;
      end
      3'd2: begin
        w.opa    = OPA_PROD;
        w.opb    = OPB_ERR;
        w.mul_en = 1'b1;
      end
      3'd3: begin
        w.opa    = OPA_PROD;
        w.opb    = OPB_CUBIC;
        w.mul_en = 1'b1;
      end
      3'd4: begin
        w.acc_op = ACC_SUB;
      end
      3'd5: begin
        w.emit = EMIT_MOTOR;
        w.last = 1'b1;
      end
      3'd6: begin
        w.emit = EMIT_PASS;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/motor_force_boost_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_force_boost_integrator
// Per-channel force boosting between a controller and its motors.
//
// Input beats carry action in in_tuser and channel, value and noise in
// in_tdata. A sensor beat returns value plus noise, saturated, and stores the
// raw value for motor channels. A motor beat on a motor channel with a
// non-zero boost rate runs the error update on one shared 18x18 multiplier
// under a seven-step control program and returns command plus error, clipped to
// +-1.0 (Q3.12). A boosted motor beat runs six program steps, four of them
// multiplier passes; a sensor or pass-through beat runs the first step and the
// pass-through step. One beat is in work at a time, so the next beat is taken
// only once the sequencer has finished the last one; in_tready is high whenever
// the sequencer is idle and out of reset, so a new beat can be taken while a
// finished result still waits in the output register.
// When the receiver stalls, the final step holds until the output register
// frees, and the stored state is written only as that step completes.
// Reset clears all stored errors and sensor values, sets boost_rate to 0 and
// motor_channels to 16. Configuration is written on cfg_we.
// ----------------------------------------------------------------------------
module motor_force_boost_integrator #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // channel[3:0], in_value[19:4], noise_value[35:20]
  input  logic [0:0]  in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_value[15:0], out_channel[19:16]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);
  import mfbi_pkg::*;

  localparam int DEPTH = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [12:0] boost_rate_r;
  logic [4:0]  motor_channels_r;

  logic signed [ERR_W-1:0] err_mem_r [DEPTH];
  logic signed [15:0]      sens_mem_r [DEPTH];

  logic               action_r;
  logic [3:0]         ch_r;
  logic [IDX_W-1:0]   idx_r;
  logic               motor_ch_r;
  logic signed [15:0] val_r;
  logic signed [15:0] noise_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [16:0] diff_r;

  logic signed [2*MUL_W-1:0] prod_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic        out_valid_r;
  logic [15:0] out_value_r;
  logic [3:0]  out_channel_r;

  seq_ctrl_t ctrl;
  logic      in_fire, cond_pass, stall, emit_fire;

  logic               in_action;
  logic [3:0]         in_ch;
  logic signed [15:0] in_val, in_noise;
  logic               in_motor_ch;
  logic [IDX_W-1:0]   in_idx;
  logic signed [ERR_W-1:0] in_err;
  logic signed [15:0] in_sens;

  logic signed [MUL_W-1:0]   opa, opb;
  logic signed [2*MUL_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]   prod_term;
  logic signed [ERR_W-1:0]   err_clip;
  logic signed [16:0]        motor_sum, sens_sum;
  logic signed [15:0]        res_motor, res_pass;

  function automatic logic signed [ERR_W-1:0] clip_q1(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(QONE)) return ERR_W'(QONE);
    if (x < -ACC_W'(QONE)) return -ERR_W'(QONE);
    return x[ERR_W-1:0];
  endfunction

  assign in_action   = in_tuser[0];
  assign in_ch       = in_tdata[3:0];
  assign in_val      = in_tdata[19:4];
  assign in_noise    = in_tdata[35:20];
  assign in_motor_ch = ({1'b0, in_ch} < motor_channels_r) && (in_ch < CHANNELS);
  assign in_idx      = in_ch[IDX_W-1:0];
  assign in_err      = in_motor_ch ? err_mem_r[in_idx] : '0;
  assign in_sens     = in_motor_ch ? sens_mem_r[in_idx] : '0;

  assign in_tready = !ctrl.busy && rst_n;
  assign in_fire   = in_tvalid && in_tready;

  assign cond_pass = (action_r == ACT_SENSOR) || (boost_rate_r == '0) || !motor_ch_r;
  assign stall     = (ctrl.word.emit != EMIT_NONE) && out_valid_r && !out_tready;
  assign emit_fire = ctrl.busy && (ctrl.word.emit != EMIT_NONE) && !stall;

  mfbi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .cond_pass (cond_pass),
    .stall     (stall),
    .ctrl      (ctrl)
  );

  always_comb begin
    case (ctrl.word.opa)
      OPA_DIFF: opa = MUL_W'(diff_r);
      OPA_ERR:  opa = MUL_W'(err_r);
      OPA_PROD: opa = prod_r[FRAC+MUL_W-1:FRAC];
      default:  opa = '0;
    endcase
    case (ctrl.word.opb)
      OPB_BOOST: opb = MUL_W'(signed'({1'b0, boost_rate_r}));
      OPB_ERR:   opb = MUL_W'(err_r);
      OPB_CUBIC: opb = MUL_W'(CUBIC_GAIN);
      default:   opb = '0;
    endcase
  end

  assign prod_nxt  = opa * opb;
  assign prod_term = prod_r[FRAC+ACC_W-1:FRAC];
  assign err_clip  = clip_q1(acc_r);
  assign motor_sum = 17'(val_r) + 17'(err_clip);
  assign res_motor = 16'(clip_q1(ACC_W'(motor_sum)));
  assign sens_sum  = 17'(val_r) + 17'(noise_r);

  always_comb begin
    if (action_r == ACT_SENSOR) begin
      if (sens_sum > 17'sd32767) res_pass = 16'sh7fff;
      else if (sens_sum < -17'sd32768) res_pass = 16'sh8000;
      else res_pass = sens_sum[15:0];
    end else begin
      res_pass = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_rate_r     <= '0;
      motor_channels_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOOST_RATE:     boost_rate_r     <= cfg_wdata;
        CFG_MOTOR_CHANNELS: motor_channels_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r   <= in_action;
      ch_r       <= in_ch;
      idx_r      <= in_idx;
      motor_ch_r <= in_motor_ch;
      val_r      <= in_val;
      noise_r    <= in_noise;
      err_r      <= in_err;
      diff_r     <= 17'(in_val) - 17'(in_sens);
    end
    if (ctrl.busy && ctrl.word.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.busy) begin
      case (ctrl.word.acc_op)
        ACC_INIT: acc_r <= ACC_W'(err_r) - ACC_W'(err_r >>> DECAY_SHIFT);
        ACC_ADD:  acc_r <= acc_r + prod_term;
        ACC_SUB:  acc_r <= acc_r - prod_term;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        err_mem_r[i]  <= '0;
        sens_mem_r[i] <= '0;
      end
    end else if (emit_fire) begin
      if (ctrl.word.emit == EMIT_MOTOR) begin
        err_mem_r[idx_r] <= err_clip;
      end else if (action_r == ACT_SENSOR && motor_ch_r) begin
        sens_mem_r[idx_r] <= val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_value_r   <= (ctrl.word.emit == EMIT_MOTOR) ? res_motor : res_pass;
      out_channel_r <= ch_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_channel_r, out_value_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while a beat is still in work");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_tvalid)
    else $error("result step completed without a valid output");

  a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && ctrl.word.emit == EMIT_MOTOR) |->
      (err_clip <= 14'sd4096 && err_clip >= -14'sd4096))
    else $error("stored boost error outside unit range");

endmodule

// File: src/mfbi_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbi_seq
// Step counter over the control program, with the pass-through jump.
// ----------------------------------------------------------------------------
module mfbi_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                cond_pass,
  input  logic                stall,
  output mfbi_pkg::seq_ctrl_t ctrl
);
  import mfbi_pkg::*;

  logic busy_r, busy_nxt;
  pc_t  pc_r, pc_nxt;
  ucode_t word;

  always_comb begin
    word     = ucode(pc_r);
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (!stall) begin
      if (word.last) begin
        busy_nxt = 1'b0;
      end else if (word.jmp_pass && cond_pass) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + pc_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctrl.busy = busy_r;
  assign ctrl.word = word;

endmodule

// File: sim/tb_motor_force_boost_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_force_boost_integrator
// Self-checking bench for the motor force boost integrator.
//
// A queue of beats feeds a clocked driver. Each accepted beat runs through a
// bit-exact model of the boost error update, and the model's result waits in
// a queue until the monitor checks it against the output beat. Directed beats
// cover sensor saturation, unstored channels, pass-through, large boost rates
// and a zero motor count. Random phases then send sensor/motor sequences under
// several register settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_motor_force_boost_integrator;
  import mfbi_pkg::*;

  localparam logic ACT_MOTOR  = 1'b1;
  localparam int   N_CH       = 16;
  localparam int   UNITY      = 4096;
  localparam int   DECAY_MUL  = 4;
  localparam int   CUBE_MUL   = 410;
  localparam int   CYCLE_CAP  = 400000;

  typedef struct {
    logic        act;
    logic [3:0]  ch;
    logic [15:0] val;
    logic [15:0] noise;
  } beat_t;

  typedef struct {
    logic [15:0] value;
    logic [3:0]  ch;
  } force_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // channel[3:0], in_value[19:4], noise_value[35:20]
  logic [0:0]  in_tuser = '0;   // action[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // out_value[15:0], out_channel[19:16]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  beat_t  beat_q[$];
  force_t force_q[$];
  beat_t  next_beat;
  force_t got_force;

  logic signed [15:0] err_mem[N_CH];
  logic signed [15:0] sensor_mem[N_CH];
  logic [12:0]        boost_q;
  logic [4:0]         motors_q;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  motor_force_boost_integrator #(.CHANNELS(N_CH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] predict_force(input logic act, input logic [3:0] ch,
                                                input logic signed [15:0] val,
                                                input logic signed [15:0] noise);
    longint e, diff, bterm, dterm, e2, e3, cterm, r;
    logic   is_motor;
    is_motor = (ch < motors_q) && (ch < N_CH);
    if (act == ACT_SENSOR) begin
      r = longint'(val) + longint'(noise);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      if (is_motor) sensor_mem[ch] = val;
    end else if (boost_q == 0 || !is_motor) begin
      r = longint'(val);
    end else begin
      e     = longint'(err_mem[ch]);
      diff  = longint'(val) - longint'(sensor_mem[ch]);
      bterm = (diff * longint'(boost_q)) >>> 12;
      dterm = (e * DECAY_MUL) >>> 12;
      e2    = (e * e) >>> 12;
      e3    = (e2 * e) >>> 12;
      cterm = (e3 * CUBE_MUL) >>> 12;
      e = e + bterm - dterm - cterm;
      if (e > UNITY) e = UNITY;
      if (e < -UNITY) e = -UNITY;
      err_mem[ch] = e[15:0];
      r = longint'(val) + e;
      if (r > UNITY) r = UNITY;
      if (r < -UNITY) r = -UNITY;
    end
    return r[15:0];
  endfunction

  // driver: predict on accept, then advance or drop valid
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        force_q.push_back('{predict_force(in_tuser[0], in_tdata[3:0], in_tdata[19:4],
                                          in_tdata[35:20]), in_tdata[3:0]});
      end
      if (!in_tvalid || in_tready) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = beat_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, next_beat.noise, next_beat.val, next_beat.ch};
          in_tuser  <= next_beat.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (force_q.size() == 0) begin
          $error("output beat with no result pending: out_tdata %h", out_tdata);
          fail_cnt++;
        end else begin
          got_force = force_q.pop_front();
          if (out_tdata[15:0] !== got_force.value) begin
            $error("out_value expected %0d got %0d", $signed(got_force.value),
                   $signed(out_tdata[15:0]));
            fail_cnt++;
          end
          if (out_tdata[19:16] !== got_force.ch) begin
            $error("out_channel expected %0d got %0d", got_force.ch, out_tdata[19:16]);
            fail_cnt++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_beat(input logic act, input logic [3:0] ch, input int val,
                           input int noise);
    beat_q.push_back('{act, ch, val[15:0], noise[15:0]});
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BOOST_RATE) boost_q = val;
    else motors_q = val[4:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (beat_q.size() > 0 || in_tvalid || force_q.size() > 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic int near_unity();
    return int'($urandom_range(12000)) - 6000;
  endfunction

  // mostly a sensor beat followed by a few motor commands near it
  task automatic add_random(input int n);
    int          k, burst, base;
    logic [3:0]  ch;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) < 7) begin
        ch   = 4'($urandom_range(15));
        base = near_unity();
        push_beat(ACT_SENSOR, ch, base,
                  $urandom_range(1) ? int'($urandom) : near_unity());
        burst = $urandom_range(4, 1);
        repeat (burst) push_beat(ACT_MOTOR, ch, base + int'($urandom_range(1024)) - 512,
                                 int'($urandom));
        k += burst + 1;
      end else begin
        push_beat(1'($urandom_range(1)), 4'($urandom_range(15)), int'($urandom),
                  int'($urandom));
        k++;
      end
    end
  endtask

  task automatic run_phase(input logic [12:0] boost, input logic [4:0] motors,
                           input int idle_pct, input int stall_pct, input int n);
    write_reg(CFG_BOOST_RATE, boost);
    write_reg(CFG_MOTOR_CHANNELS, {8'b0, motors});
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    add_random(n);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < N_CH; i++) begin
      err_mem[i]    = '0;
      sensor_mem[i] = '0;
    end
    boost_q  = '0;
    motors_q = 5'd16;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: boosting off
    push_beat(ACT_SENSOR, 0, 32767, 32767);
    push_beat(ACT_SENSOR, 15, -32768, -32768);
    push_beat(ACT_SENSOR, 1, 0, 0);
    push_beat(ACT_SENSOR, 3, 4096, -1);
    push_beat(ACT_MOTOR, 0, 32767, 0);
    push_beat(ACT_MOTOR, 15, -32768, 1234);
    wait_drained();

    write_reg(CFG_BOOST_RATE, 13'd4096);
    write_reg(CFG_MOTOR_CHANNELS, 13'd4);
    push_beat(ACT_SENSOR, 2, 1000, 5);
    push_beat(ACT_MOTOR, 2, 3000, 0);
    push_beat(ACT_MOTOR, 2, 3000, 0);
    push_beat(ACT_MOTOR, 2, -4096, 0);
    push_beat(ACT_SENSOR, 12, 2222, 0);
    push_beat(ACT_MOTOR, 9, -1234, 0);
    push_beat(ACT_MOTOR, 3, 4096, 0);
    wait_drained();

    write_reg(CFG_BOOST_RATE, 13'h1fff);
    push_beat(ACT_MOTOR, 2, -32768, 0);
    push_beat(ACT_MOTOR, 2, 32767, 0);
    push_beat(ACT_MOTOR, 1, 0, 0);
    wait_drained();

    write_reg(CFG_MOTOR_CHANNELS, 13'd0);
    push_beat(ACT_MOTOR, 0, 500, 0);
    push_beat(ACT_SENSOR, 0, 777, 1);
    wait_drained();

    // hold the sender mid-phase until every result is back
    run_phase(13'd300, 5'd16, 0, 0, 50);
    add_random(50);
    wait_drained();
    run_phase(13'h1fff, 5'd1, 66, 0, 100);
    run_phase(13'd1, 5'd31, 0, 66, 100);
    run_phase(13'($urandom_range(4096, 1)), 5'($urandom_range(16, 1)), 20, 20, 100);
    run_phase(13'd4096, 5'd8, 0, 0, 100);
    run_phase(13'd0, 5'd0, 20, 20, 100);

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
